/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define MPMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mpmc assertion failed");

// Clocked check that also holds around reset.
`define MPMC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mpmc assertion failed");

`endif

/* design/mpmc_pkg.sv */
`default_nettype none
package mpmc_pkg;

  localparam int MAX_NODES   = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int LET_W       = $clog2(ALPHABET);
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CADDR_W     = $clog2(CHILD_DEPTH);
  localparam int SYM_W       = 5;
  localparam int COUNT_W     = 16;
  localparam int EP_W        = 8;
  localparam logic [EP_W-1:0] EP_LAST = EP_W'(2 ** EP_W - 2);
  localparam logic [EP_W-1:0] EP_FREE = '1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_SCAN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_BUILD   = 2'd1,
    KIND_TOTAL   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [COUNT_W-1:0] match_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] symbol;
    logic             sym_ok;
    logic             last;
  } cmd_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_END,
    S_CNT_WR,
    S_B_RT_RD,
    S_B_RT_CHK,
    S_B_POP,
    S_B_CUR,
    S_B_FCUR,
    S_B_CH_RD,
    S_B_CH_CHK,
    S_B_W_RD,
    S_B_W_CHK,
    S_B_F_RD,
    S_SC_RD,
    S_SC_CHK,
    S_SC_F_RD,
    S_SC_T,
    S_SC_T_CHK,
    S_SC_END,
    S_EMIT,
    S_SWEEP
  } state_e;

  function automatic logic [CADDR_W-1:0] child_addr(input logic [NODE_W-1:0]  node,
                                                    input logic [CADDR_W-1:0] sym);
    return CADDR_W'(node) * CADDR_W'(ALPHABET) + sym;
  endfunction

endpackage
`default_nettype wire

/* design/mpmc_ram.sv */
`default_nettype none
module mpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/mpmc_front.sv */
`default_nettype none
module mpmc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mpmc_pkg::in_t   item_i,
  output      logic            full_o,
  output      logic            valid_o,
  output      mpmc_pkg::cmd_t  cmd_o,
  input  wire logic            take_i
);

  mpmc_pkg::cmd_t                   ent_q [mpmc_pkg::QDEPTH];
  mpmc_pkg::cmd_t                   cls;
  logic [mpmc_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [mpmc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  // classify the raw item before it is queued
  always_comb begin
    cls.symbol = item_i.symbol;
    cls.last   = item_i.last;
    cls.sym_ok = 32'(item_i.symbol) < 32'(mpmc_pkg::ALPHABET);
    cls.op     = mpmc_pkg::op_e'(item_i.cmd);
  end

  assign full_o  = (cnt_q == mpmc_pkg::QCNT_W'(mpmc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + mpmc_pkg::QCNT_W'(do_push) - mpmc_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* design/mpmc_engine.sv */
`default_nettype none
module mpmc_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire mpmc_pkg::cmd_t  cmd_i,
  output      logic            take_o,
  output      logic            out_valid_o,
  output      mpmc_pkg::out_t  out_o,
  input  wire logic            pop_i
);

  localparam int NW = mpmc_pkg::NODE_W;
  localparam int CW = mpmc_pkg::CNT_W;
  localparam int LW = mpmc_pkg::LET_W;
  localparam int KW = mpmc_pkg::COUNT_W;
  localparam int EW = mpmc_pkg::EP_W;
  localparam int AW = mpmc_pkg::CADDR_W;

  mpmc_pkg::state_e state_q, state_d;

  logic [CW-1:0] used_q, used_d, head_q, head_d, tail_q, tail_d, guard_q, guard_d;
  logic [NW-1:0] ins_q, ins_d, scan_q, scan_d, cur_q, cur_d, fcur_q, fcur_d;
  logic [NW-1:0] c_q, c_d, p_q, p_d, sweep_q, sweep_d, initn_q, initn_d;
  logic [LW-1:0] let_q, let_d;
  logic [KW-1:0] total_q, total_d;
  logic [EW-1:0] epoch_q, epoch_d;
  logic          ovf_q, ovf_d, init_ins_q, init_ins_d, swp_pend_q, swp_pend_d;
  logic          outv_q, outv_d;
  mpmc_pkg::cmd_t cur_cmd_q, cur_cmd_d;
  mpmc_pkg::out_t pend_q, pend_d, out_q, out_d;

  // memory ports
  logic [NW-1:0] ca_node;
  logic [AW-1:0] ca_sym, caddr;
  logic          child_we;
  logic [NW-1:0] child_wd, child_rd;
  logic          fail_we;
  logic [NW-1:0] fail_wa, fail_wd, fail_ra, fail_rd;
  logic          count_we;
  logic [NW-1:0] count_wa, count_ra;
  logic [KW-1:0] count_wd, count_rd;
  logic          mark_we;
  logic [NW-1:0] mark_wa, mark_ra;
  logic [EW-1:0] mark_wd, mark_rd;
  logic          q_we;
  logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

  logic          let_end, guard_ok, tail_ok, out_free;
  logic [KW:0]   sum;

  assign caddr    = mpmc_pkg::child_addr(ca_node, ca_sym);
  assign let_end  = (let_q == LW'(mpmc_pkg::ALPHABET - 1));
  assign guard_ok = (guard_q < CW'(mpmc_pkg::MAX_NODES));
  assign tail_ok  = (tail_q < CW'(mpmc_pkg::MAX_NODES));
  assign out_free = !outv_q || pop_i;
  assign sum      = {1'b0, total_q} + {1'b0, count_rd};

  mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::CHILD_DEPTH)) u_child (
    .clk_i, .we_i(child_we), .waddr_i(caddr), .wdata_i(child_wd),
    .raddr_i(caddr), .rdata_o(child_rd)
  );
  mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_fail (
    .clk_i, .we_i(fail_we), .waddr_i(fail_wa), .wdata_i(fail_wd),
    .raddr_i(fail_ra), .rdata_o(fail_rd)
  );
  mpmc_ram #(.WIDTH(KW), .DEPTH(mpmc_pkg::MAX_NODES)) u_count (
    .clk_i, .we_i(count_we), .waddr_i(count_wa), .wdata_i(count_wd),
    .raddr_i(count_ra), .rdata_o(count_rd)
  );
  mpmc_ram #(.WIDTH(EW), .DEPTH(mpmc_pkg::MAX_NODES)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(mark_ra), .rdata_o(mark_rd)
  );
  mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_bfsq (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .raddr_i(q_ra), .rdata_o(q_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpmc_pkg::S_INIT: begin
        if (let_end) state_d = init_ins_q ? mpmc_pkg::S_INS_END : mpmc_pkg::S_IDLE;
      end
      mpmc_pkg::S_IDLE: begin
        if (valid_i) begin
          case (cmd_i.op)
            mpmc_pkg::CMD_CLEAR:  state_d = mpmc_pkg::S_INIT;
            mpmc_pkg::CMD_INSERT: state_d = (!ovf_q && cmd_i.sym_ok) ? mpmc_pkg::S_INS_RD
                                                                      : mpmc_pkg::S_INS_END;
            mpmc_pkg::CMD_BUILD:  state_d = mpmc_pkg::S_B_RT_RD;
            default:              state_d = cmd_i.sym_ok ? mpmc_pkg::S_SC_RD
                                                         : mpmc_pkg::S_SC_END;
          endcase
        end
      end
      mpmc_pkg::S_INS_RD: begin
        if (child_rd == '0 && used_q < CW'(mpmc_pkg::MAX_NODES)) state_d = mpmc_pkg::S_INIT;
        else state_d = mpmc_pkg::S_INS_END;
      end
      mpmc_pkg::S_INS_END: begin
        if (!cur_cmd_q.last) state_d = mpmc_pkg::S_IDLE;
        else if (!ovf_q) state_d = mpmc_pkg::S_CNT_WR;
        else state_d = mpmc_pkg::S_EMIT;
      end
      mpmc_pkg::S_CNT_WR:   state_d = mpmc_pkg::S_EMIT;
      mpmc_pkg::S_B_RT_RD:  state_d = mpmc_pkg::S_B_RT_CHK;
      mpmc_pkg::S_B_RT_CHK: state_d = let_end ? mpmc_pkg::S_B_POP : mpmc_pkg::S_B_RT_RD;
      mpmc_pkg::S_B_POP:    state_d = (head_q < tail_q) ? mpmc_pkg::S_B_CUR : mpmc_pkg::S_EMIT;
      mpmc_pkg::S_B_CUR:    state_d = mpmc_pkg::S_B_FCUR;
      mpmc_pkg::S_B_FCUR:   state_d = mpmc_pkg::S_B_CH_RD;
      mpmc_pkg::S_B_CH_RD:  state_d = mpmc_pkg::S_B_CH_CHK;
      mpmc_pkg::S_B_CH_CHK: begin
        if (child_rd != '0) state_d = mpmc_pkg::S_B_W_RD;
        else state_d = let_end ? mpmc_pkg::S_B_POP : mpmc_pkg::S_B_CH_RD;
      end
      mpmc_pkg::S_B_W_RD:   state_d = mpmc_pkg::S_B_W_CHK;
      mpmc_pkg::S_B_W_CHK: begin
        if (p_q != '0 && child_rd == '0 && guard_ok) state_d = mpmc_pkg::S_B_F_RD;
        else state_d = let_end ? mpmc_pkg::S_B_POP : mpmc_pkg::S_B_CH_RD;
      end
      mpmc_pkg::S_B_F_RD:   state_d = mpmc_pkg::S_B_W_RD;
      mpmc_pkg::S_SC_RD:    state_d = mpmc_pkg::S_SC_CHK;
      mpmc_pkg::S_SC_CHK: begin
        if (child_rd == '0 && p_q != '0 && guard_ok) state_d = mpmc_pkg::S_SC_F_RD;
        else state_d = mpmc_pkg::S_SC_T;
      end
      mpmc_pkg::S_SC_F_RD:  state_d = mpmc_pkg::S_SC_RD;
      mpmc_pkg::S_SC_T: begin
        state_d = (p_q == '0 || !guard_ok) ? mpmc_pkg::S_SC_END : mpmc_pkg::S_SC_T_CHK;
      end
      mpmc_pkg::S_SC_T_CHK: begin
        state_d = (mark_rd == epoch_q) ? mpmc_pkg::S_SC_END : mpmc_pkg::S_SC_T;
      end
      mpmc_pkg::S_SC_END:   state_d = cur_cmd_q.last ? mpmc_pkg::S_EMIT : mpmc_pkg::S_IDLE;
      mpmc_pkg::S_EMIT: begin
        if (out_free) state_d = swp_pend_q ? mpmc_pkg::S_SWEEP : mpmc_pkg::S_IDLE;
      end
      mpmc_pkg::S_SWEEP: begin
        if ({1'b0, sweep_q} + CW'(1) == used_q) state_d = mpmc_pkg::S_IDLE;
      end
      default: state_d = mpmc_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    used_d     = used_q;     head_d   = head_q;   tail_d    = tail_q;
    guard_d    = guard_q;    ins_d    = ins_q;    scan_d    = scan_q;
    cur_d      = cur_q;      fcur_d   = fcur_q;   c_d       = c_q;
    p_d        = p_q;        sweep_d  = sweep_q;  initn_d   = initn_q;
    let_d      = let_q;      total_d  = total_q;  epoch_d   = epoch_q;
    ovf_d      = ovf_q;      init_ins_d = init_ins_q;
    swp_pend_d = swp_pend_q; cur_cmd_d  = cur_cmd_q;
    pend_d     = pend_q;     out_d    = out_q;
    outv_d     = outv_q && !pop_i;
    take_o     = 1'b0;
    ca_node    = p_q;
    ca_sym     = AW'(cur_cmd_q.symbol);
    child_we   = 1'b0;       child_wd = '0;
    fail_we    = 1'b0;       fail_wa  = c_q;      fail_wd   = '0;
    fail_ra    = p_q;
    count_we   = 1'b0;       count_wa = ins_q;    count_wd  = '0;
    count_ra   = p_q;
    mark_we    = 1'b0;       mark_wa  = p_q;      mark_wd   = epoch_q;
    mark_ra    = p_q;
    q_we       = 1'b0;       q_wa     = tail_q[NW-1:0];
    q_wd       = c_q;        q_ra     = head_q[NW-1:0];

    case (state_q)
      mpmc_pkg::S_INIT: begin
        // wipe one child slot a cycle; node fields on the first one
        ca_node  = initn_q;
        ca_sym   = AW'(let_q);
        child_we = 1'b1;
        if (let_q == '0) begin
          fail_we  = 1'b1; fail_wa  = initn_q;
          count_we = 1'b1; count_wa = initn_q;
          mark_we  = 1'b1; mark_wa  = initn_q; mark_wd = mpmc_pkg::EP_FREE;
        end
        let_d = let_end ? '0 : let_q + 1'b1;
      end
      mpmc_pkg::S_IDLE: begin
        if (valid_i) begin
          take_o    = 1'b1;
          cur_cmd_d = cmd_i;
          case (cmd_i.op)
            mpmc_pkg::CMD_CLEAR: begin
              used_d = CW'(1); ins_d = '0; scan_d = '0; total_d = '0; ovf_d = 1'b0;
              initn_d = '0; init_ins_d = 1'b0; let_d = '0;
            end
            mpmc_pkg::CMD_INSERT: begin
              ca_node = ins_q;
              ca_sym  = AW'(cmd_i.symbol);
            end
            mpmc_pkg::CMD_BUILD: begin
              head_d = '0; tail_d = '0; let_d = '0;
            end
            default: begin
              if (cmd_i.sym_ok) begin
                p_d = scan_q; guard_d = '0;
              end else begin
                scan_d = '0;
              end
            end
          endcase
        end
      end
      mpmc_pkg::S_INS_RD: begin
        ca_node = ins_q;
        if (child_rd != '0) begin
          ins_d = child_rd;
        end else if (used_q < CW'(mpmc_pkg::MAX_NODES)) begin
          // allocate, link from parent, then clear the new row
          child_we   = 1'b1;
          child_wd   = used_q[NW-1:0];
          ins_d      = used_q[NW-1:0];
          initn_d    = used_q[NW-1:0];
          used_d     = used_q + 1'b1;
          init_ins_d = 1'b1;
          let_d      = '0;
        end else begin
          ovf_d = 1'b1;
        end
      end
      mpmc_pkg::S_INS_END: begin
        count_ra = ins_q;
        if (cur_cmd_q.last) begin
          pend_d.kind        = mpmc_pkg::KIND_PATTERN;
          pend_d.match_count = '0;
          pend_d.overflow    = ovf_q;
          if (ovf_q) begin
            ins_d = '0; ovf_d = 1'b0;
          end
        end
      end
      mpmc_pkg::S_CNT_WR: begin
        if (count_rd != '1) begin
          count_we = 1'b1;
          count_wd = count_rd + 1'b1;
        end
        ins_d = '0; ovf_d = 1'b0;
      end
      mpmc_pkg::S_B_RT_RD: begin
        ca_node = '0;
        ca_sym  = AW'(let_q);
      end
      mpmc_pkg::S_B_RT_CHK: begin
        if (child_rd != '0 && tail_ok) begin
          fail_we = 1'b1; fail_wa = child_rd; fail_wd = '0;
          q_we    = 1'b1; q_wd    = child_rd;
          tail_d  = tail_q + 1'b1;
        end
        let_d = let_end ? '0 : let_q + 1'b1;
      end
      mpmc_pkg::S_B_POP: begin
        if (head_q < tail_q) begin
          head_d = head_q + 1'b1;
        end else begin
          pend_d.kind = mpmc_pkg::KIND_BUILD; pend_d.match_count = '0; pend_d.overflow = 1'b0;
        end
      end
      mpmc_pkg::S_B_CUR: begin
        cur_d   = q_rd;
        fail_ra = q_rd;
      end
      mpmc_pkg::S_B_FCUR: begin
        fcur_d = fail_rd;
        let_d  = '0;
      end
      mpmc_pkg::S_B_CH_RD: begin
        ca_node = cur_q;
        ca_sym  = AW'(let_q);
      end
      mpmc_pkg::S_B_CH_CHK: begin
        if (child_rd != '0) begin
          c_d = child_rd; p_d = fcur_q; guard_d = '0;
        end else begin
          let_d = let_end ? '0 : let_q + 1'b1;
        end
      end
      mpmc_pkg::S_B_W_RD: begin
        ca_sym = AW'(let_q);
      end
      mpmc_pkg::S_B_W_CHK: begin
        if (!(p_q != '0 && child_rd == '0 && guard_ok)) begin
          fail_we = 1'b1;
          fail_wd = (child_rd != '0) ? child_rd : p_q;
          if (tail_ok) begin
            q_we   = 1'b1;
            tail_d = tail_q + 1'b1;
          end
          let_d = let_end ? '0 : let_q + 1'b1;
        end
      end
      mpmc_pkg::S_B_F_RD: begin
        p_d     = fail_rd;
        guard_d = guard_q + 1'b1;
      end
      mpmc_pkg::S_SC_CHK: begin
        if (!(child_rd == '0 && p_q != '0 && guard_ok)) begin
          p_d     = (child_rd != '0) ? child_rd : p_q;
          scan_d  = (child_rd != '0) ? child_rd : p_q;
          guard_d = '0;
        end
      end
      mpmc_pkg::S_SC_F_RD: begin
        p_d     = fail_rd;
        guard_d = guard_q + 1'b1;
      end
      mpmc_pkg::S_SC_T_CHK: begin
        // unmarked in this text: add its count, mark it, follow the link
        if (mark_rd != epoch_q) begin
          total_d = sum[KW] ? '1 : sum[KW-1:0];
          mark_we = 1'b1;
          p_d     = fail_rd;
          guard_d = guard_q + 1'b1;
        end
      end
      mpmc_pkg::S_SC_END: begin
        if (cur_cmd_q.last) begin
          pend_d.kind = mpmc_pkg::KIND_TOTAL; pend_d.match_count = total_q; pend_d.overflow = 1'b0;
          total_d = '0;
          scan_d  = '0;
          // new text epoch; on wrap, old marks must be wiped
          if (epoch_q == mpmc_pkg::EP_LAST) begin
            epoch_d = '0; swp_pend_d = 1'b1; sweep_d = '0;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      mpmc_pkg::S_EMIT: begin
        if (out_free) begin
          outv_d = 1'b1;
          out_d  = pend_q;
        end
      end
      mpmc_pkg::S_SWEEP: begin
        mark_we = 1'b1; mark_wa = sweep_q; mark_wd = mpmc_pkg::EP_FREE;
        if ({1'b0, sweep_q} + CW'(1) == used_q) swp_pend_d = 1'b0;
        else sweep_d = sweep_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = outv_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    cur_cmd_q <= cur_cmd_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
    cur_q     <= cur_d;
    fcur_q    <= fcur_d;
    c_q       <= c_d;
    p_q       <= p_d;
    guard_q   <= guard_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
    sweep_q   <= sweep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mpmc_pkg::S_INIT;
      used_q     <= CW'(1);
      ins_q      <= '0;
      scan_q     <= '0;
      initn_q    <= '0;
      let_q      <= '0;
      total_q    <= '0;
      epoch_q    <= '0;
      ovf_q      <= 1'b0;
      init_ins_q <= 1'b0;
      swp_pend_q <= 1'b0;
      outv_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      ins_q      <= ins_d;
      scan_q     <= scan_d;
      initn_q    <= initn_d;
      let_q      <= let_d;
      total_q    <= total_d;
      epoch_q    <= epoch_d;
      ovf_q      <= ovf_d;
      init_ins_q <= init_ins_d;
      swp_pend_q <= swp_pend_d;
      outv_q     <= outv_d;
    end
  end

endmodule
`default_nettype wire

/* design/multi_pattern_match_counter.sv */
// Aho-Corasick keyword counter, 26 letters, up to 4096 trie nodes. Items enter a
// four-deep command queue and are executed one at a time by a sequencer over
// single-port-read RAMs (child table, failure links, counts, text marks, BFS
// queue); every RAM read is registered, which sets the timing. An insert letter
// reads the child slot and, when a node is allocated, clears its child row one
// slot a cycle; a pattern end bumps the end node's count unless it overflowed. A
// scan letter reads the child slot, follows failure steps on a miss, then walks
// the output chain, counting each new node and stopping at a node already
// counted. A build queues the root's children, then pops each node and walks
// failure steps for each child to set its link. After reset and after each clear
// the root row is cleared before the next item is taken. Seen marks are per-text
// epochs; every 255th text end adds a sweep that clears the marks of all used nodes.
`default_nettype none
module multi_pattern_match_counter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output      logic            full,
  input  wire mpmc_pkg::in_t   item_i,
  output      logic            empty,
  input  wire logic            pop,
  output      mpmc_pkg::out_t  result_o
);

  logic           cmd_valid, cmd_take, out_valid;
  mpmc_pkg::cmd_t cmd;

  mpmc_front u_front (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i,
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd),
    .take_i  (cmd_take)
  );

  mpmc_engine u_engine (
    .clk_i, .rst_ni,
    .valid_i     (cmd_valid),
    .cmd_i       (cmd),
    .take_o      (cmd_take),
    .out_valid_o (out_valid),
    .out_o       (result_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

/* design/mpmc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module mpmc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           push,
  input wire logic           full,
  input wire mpmc_pkg::in_t  item_i,
  input wire logic           empty,
  input wire logic           pop,
  input wire mpmc_pkg::out_t result_o
);

  logic unused_in;
  assign unused_in = push ^ full ^ (^item_i);

  `MPMC_ASSERT(a_out_hold, !empty && !pop |=> !empty && $stable(result_o))
  `MPMC_ASSERT(a_build_clean, !empty && result_o.kind == mpmc_pkg::KIND_BUILD |-> result_o.match_count == '0 && !result_o.overflow)
  `MPMC_ASSERT(a_pattern_no_count, !empty && result_o.kind == mpmc_pkg::KIND_PATTERN |-> result_o.match_count == '0)
  `MPMC_ASSERT(a_total_no_ovf, !empty && result_o.kind == mpmc_pkg::KIND_TOTAL |-> !result_o.overflow)
  `MPMC_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> empty)

endmodule

bind multi_pattern_match_counter mpmc_checker u_chk (.*);
`default_nettype wire
